FILE: rtl/core/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies; imported by bcc_step, button_click_classifier and the testbench.
`default_nettype none

package bcc_pkg;

	// Width of each configuration register
	localparam int CFG_W = 14;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [1:0] REG_GAP        = 2'd2;

	// Register values after reset
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 14'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 14'd1000;
	localparam logic [CFG_W-1:0] GAP_RST        = 14'd300;

	// Event codes
	typedef logic [1:0] event_kind_t;
	localparam event_kind_t EV_SINGLE = 2'd0;
	localparam event_kind_t EV_DOUBLE = 2'd1;
	localparam event_kind_t EV_LONG   = 2'd2;

	// Single-bit state of the classifier
	typedef struct packed {
		logic started;
		logic raw_previous;
		logic stable_level;
		logic long_reported;
		logic awaiting_second;
	} bcc_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/bcc_step.sv
// Next-state and event logic for one tick of the click classifier.
// Depends on bcc_pkg; instantiated by button_click_classifier.
`default_nettype none

module bcc_step
	import bcc_pkg::*;
#(
	parameter int TIME_WIDTH = 16
) (
	input  wire logic [CFG_W-1:0]      debounce_ms,
	input  wire logic [CFG_W-1:0]      long_press_ms,
	input  wire logic [CFG_W-1:0]      double_click_gap_ms,
	input  wire bcc_flags_t            flags,
	input  wire logic [TIME_WIDTH-1:0] debounce_elapsed,
	input  wire logic [TIME_WIDTH-1:0] hold_elapsed,
	input  wire logic [TIME_WIDTH-1:0] gap_elapsed,
	input  wire logic                  raw_pressed,
	input  wire logic [7:0]            elapsed_ms,
	output bcc_flags_t                 flags_nx,
	output logic [TIME_WIDTH-1:0]      debounce_elapsed_nx,
	output logic [TIME_WIDTH-1:0]      hold_elapsed_nx,
	output logic [TIME_WIDTH-1:0]      gap_elapsed_nx,
	output logic                       ev_valid,
	output event_kind_t                ev_kind
);

	localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	function automatic logic [TIME_WIDTH-1:0] sat_add(
		input logic [TIME_WIDTH-1:0] acc,
		input logic [7:0]            inc
	);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, acc} + (TIME_WIDTH+1)'(inc);
		return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
	endfunction

	// Accumulator reached its limit
	function automatic logic reached(
		input logic [TIME_WIDTH-1:0] acc,
		input logic [CFG_W-1:0]      lim
	);
		return CMP_W'(acc) >= CMP_W'(lim);
	endfunction

	always_comb begin
		bcc_flags_t            f;
		logic [TIME_WIDTH-1:0] deb;
		logic [TIME_WIDTH-1:0] hold;
		logic [TIME_WIDTH-1:0] gap;

		f        = flags;
		deb      = debounce_elapsed;
		hold     = hold_elapsed;
		gap      = gap_elapsed;
		ev_valid = 1'b0;
		ev_kind  = EV_SINGLE;

		// first tick: adopt the raw level and clear everything else
		if (!f.started) begin
			f.raw_previous    = raw_pressed;
			f.stable_level    = raw_pressed;
			f.started         = 1'b1;
			f.long_reported   = 1'b0;
			f.awaiting_second = 1'b0;
			deb  = '0;
			hold = '0;
			gap  = '0;
		end

		if (raw_pressed != f.raw_previous) begin
			f.raw_previous = raw_pressed;
			deb = '0;
		end else if (!reached(deb, debounce_ms)) begin
			deb = sat_add(deb, elapsed_ms);
			if (reached(deb, debounce_ms) && f.stable_level != raw_pressed) begin
				f.stable_level = raw_pressed;
				if (raw_pressed) begin
					hold = '0;
					f.long_reported = 1'b0;
				end else begin
					if (!f.long_reported) begin
						gap = '0;
						if (f.awaiting_second) begin
							f.awaiting_second = 1'b0;
							ev_valid = 1'b1;
							ev_kind  = EV_DOUBLE;
						end else begin
							f.awaiting_second = 1'b1;
						end
					end
					f.long_reported = 1'b0;
				end
			end
		end

		if (f.stable_level) begin
			hold = sat_add(hold, elapsed_ms);
			if (!f.long_reported && reached(hold, long_press_ms)) begin
				f.long_reported   = 1'b1;
				f.awaiting_second = 1'b0;
				gap      = '0;
				ev_valid = 1'b1;
				ev_kind  = EV_LONG;
			end
		end else if (f.awaiting_second) begin
			gap = sat_add(gap, elapsed_ms);
			if (reached(gap, double_click_gap_ms)) begin
				f.awaiting_second = 1'b0;
				gap      = '0;
				ev_valid = 1'b1;
				ev_kind  = EV_SINGLE;
			end
		end

		flags_nx            = f;
		debounce_elapsed_nx = deb;
		hold_elapsed_nx     = hold;
		gap_elapsed_nx      = gap;
	end

endmodule

`default_nettype wire

FILE: rtl/core/button_click_classifier.sv
// Top level of the button click classifier: tick register, state and output register.
// Depends on bcc_pkg and bcc_step.
`default_nettype none

// Debounced single / double / long press detector. Each transfer on the slave
// stream is one time tick: the sampled button level and the milliseconds since
// the previous tick. A tick that completes a gesture produces one transfer on
// the master stream carrying the event code (0 single click, 1 double click,
// 2 long press); other ticks produce nothing. A tick is taken every cycle
// unless the block stalls: it lands in an input register, from which one pass
// of compare and saturating-add logic updates the state and loads the output
// register, so the sustained rate is one tick per cycle while nothing stalls.
// The only stall comes from the output register, when it holds an unaccepted
// event and the waiting tick would produce another. Time accumulators are
// TIME_WIDTH bits and saturate rather than wrap. Write the three timing
// registers only while no tick is in flight.
module button_click_classifier
	import bcc_pkg::*;
#(
	parameter int TIME_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write port
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	// tick stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [15:0]      s_tdata,  // [0] raw_pressed, [8:1] elapsed_ms, rest zero
	// event stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata   // [1:0] event_kind, rest zero
);

	// timing registers
	logic [CFG_W-1:0] debounce_ms_q;
	logic [CFG_W-1:0] long_press_ms_q;
	logic [CFG_W-1:0] gap_ms_q;

	// tick register
	logic       valid_s1;
	logic       raw_s1;
	logic [7:0] elapsed_s1;

	// classifier state
	bcc_flags_t            flags_q;
	logic [TIME_WIDTH-1:0] deb_q;
	logic [TIME_WIDTH-1:0] hold_q;
	logic [TIME_WIDTH-1:0] gap_q;

	// next state from the step logic
	bcc_flags_t            flags_nx;
	logic [TIME_WIDTH-1:0] deb_nx;
	logic [TIME_WIDTH-1:0] hold_nx;
	logic [TIME_WIDTH-1:0] gap_nx;
	logic                  ev_valid;
	event_kind_t           ev_kind;

	// output register
	logic        out_valid_q;
	event_kind_t out_kind_q;

	logic out_free;
	logic advance;

	// The output slot can take a new event if empty or being drained.
	assign out_free = !out_valid_q || m_tready;
	// A tick with no event never waits on the output side.
	assign advance  = valid_s1 && (!ev_valid || out_free);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_kind_q};

	// Register writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q   <= DEBOUNCE_RST;
			long_press_ms_q <= LONG_PRESS_RST;
			gap_ms_q        <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_ms_q   <= cfg_wdata;
				REG_LONG_PRESS: long_press_ms_q <= cfg_wdata;
				REG_GAP:        gap_ms_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Capture the tick on each slave transfer; hold it while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1     <= s_tdata[0];
			elapsed_s1 <= s_tdata[8:1];
		end
	end

	bcc_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.debounce_ms         (debounce_ms_q),
		.long_press_ms       (long_press_ms_q),
		.double_click_gap_ms (gap_ms_q),
		.flags               (flags_q),
		.debounce_elapsed    (deb_q),
		.hold_elapsed        (hold_q),
		.gap_elapsed         (gap_q),
		.raw_pressed         (raw_s1),
		.elapsed_ms          (elapsed_s1),
		.flags_nx            (flags_nx),
		.debounce_elapsed_nx (deb_nx),
		.hold_elapsed_nx     (hold_nx),
		.gap_elapsed_nx      (gap_nx),
		.ev_valid            (ev_valid),
		.ev_kind             (ev_kind)
	);

	// Advance the state once per consumed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			deb_q   <= '0;
			hold_q  <= '0;
			gap_q   <= '0;
		end else if (advance) begin
			flags_q <= flags_nx;
			deb_q   <= deb_nx;
			hold_q  <= hold_nx;
			gap_q   <= gap_nx;
		end
	end

	// Load a new event, or drop the current one once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ev_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev_valid) begin
			out_kind_q <= ev_kind;
		end
	end

	// An event code outside the three gestures never leaves the block.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == EV_SINGLE || m_tdata[1:0] == EV_DOUBLE ||
			m_tdata[1:0] == EV_LONG))
		else $error("illegal event code on output");

	// A stalled tick stays in the input register.
	a_tick_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("tick lost while stalled");

	// A double click clears the pending second-click wait.
	a_double_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ev_valid && ev_kind == EV_DOUBLE) |=> !flags_q.awaiting_second)
		else $error("wait still armed after double click");

	// A long press marks itself reported and cancels any wait.
	a_long_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ev_valid && ev_kind == EV_LONG) |=>
			(flags_q.long_reported && !flags_q.awaiting_second))
		else $error("long press not recorded");

	// An event is only loaded into a free output slot.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ev_valid) |-> out_free)
		else $error("event overwrote a pending result");

endmodule

`default_nettype wire

FILE: tb/button_click_classifier_checker.sv
// Checker for the button click classifier: follows the tick and event streams,
// predicts the gesture events and compares them with what the block sends.
// Depends on bcc_pkg for the register indexes, reset values and event codes.
module button_click_classifier_checker
	import bcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [15:0]      s_tdata,  // [0] raw_pressed, [8:1] elapsed_ms
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [7:0]       m_tdata,  // [1:0] event_kind
	output int                    mismatch_count,
	output int                    events_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACC_W = 16;
	typedef logic [ACC_W-1:0] acc_t;

	logic [CFG_W-1:0] debounce_set, long_set, gap_set;
	logic             started, raw_seen, stable, long_done, waiting;
	acc_t             settle_acc, hold_acc, gap_acc;
	event_kind_t      expected_events[$];
	logic             fired;
	event_kind_t      kind_now, kind_due;

	function automatic acc_t sat_add(input acc_t acc, input logic [7:0] inc);
		logic [ACC_W:0] sum;
		sum = {1'b0, acc} + {{(ACC_W-7){1'b0}}, inc};
		return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
	endfunction

	// One tick of the gesture classifier; at most one event per tick.
	task automatic classify_tick(input logic raw, input logic [7:0] dt,
			output logic hit, output event_kind_t kind);
		hit = 1'b0;
		kind = EV_SINGLE;
		if (!started) begin
			raw_seen = raw;
			stable = raw;
			started = 1'b1;
			settle_acc = '0;
			hold_acc = '0;
			gap_acc = '0;
			long_done = 1'b0;
			waiting = 1'b0;
		end
		if (raw != raw_seen) begin
			raw_seen = raw;
			settle_acc = '0;
		end else if (settle_acc < debounce_set) begin
			settle_acc = sat_add(settle_acc, dt);
			if (settle_acc >= debounce_set && stable != raw) begin
				stable = raw;
				if (raw) begin
					hold_acc = '0;
					long_done = 1'b0;
				end else begin
					// a release after a long press arms nothing
					if (!long_done) begin
						gap_acc = '0;
						if (waiting) begin
							waiting = 1'b0;
							hit = 1'b1;
							kind = EV_DOUBLE;
						end else begin
							waiting = 1'b1;
						end
					end
					long_done = 1'b0;
				end
			end
		end
		if (stable) begin
			hold_acc = sat_add(hold_acc, dt);
			if (!long_done && hold_acc >= long_set) begin
				long_done = 1'b1;
				waiting = 1'b0;
				gap_acc = '0;
				hit = 1'b1;
				kind = EV_LONG;
			end
		end else if (waiting) begin
			gap_acc = sat_add(gap_acc, dt);
			if (gap_acc >= gap_set) begin
				waiting = 1'b0;
				gap_acc = '0;
				hit = 1'b1;
				kind = EV_SINGLE;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_set = DEBOUNCE_RST;
			long_set = LONG_PRESS_RST;
			gap_set = GAP_RST;
			started = 1'b0;
			raw_seen = 1'b0;
			stable = 1'b0;
			long_done = 1'b0;
			waiting = 1'b0;
			settle_acc = '0;
			hold_acc = '0;
			gap_acc = '0;
			expected_events.delete();
			mismatch_count = 0;
			events_due = 0;
		end else begin
			// compare the outgoing event before queueing anything from this edge
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected event, expected none, got %0d", $time, m_tdata);
					mismatch_count++;
				end else begin
					kind_due = expected_events.pop_front();
					if (m_tdata !== {6'b0, kind_due}) begin
						$display("%0t: event mismatch, expected %0d, got %0d",
							$time, {6'b0, kind_due}, m_tdata);
						mismatch_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE:   debounce_set = cfg_wdata;
					REG_LONG_PRESS: long_set = cfg_wdata;
					REG_GAP:        gap_set = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				classify_tick(s_tdata[0], s_tdata[8:1], fired, kind_now);
				if (fired)
					expected_events.push_back(kind_now);
			end
			events_due = expected_events.size();
		end
	end

endmodule

FILE: tb/button_click_classifier_tb.sv
// Top of the button click classifier testbench: clock, reset, tick stimulus,
// event sink and the final verdict. Depends on bcc_pkg, the block and
// button_click_classifier_checker, which does all the prediction and comparison.
module button_click_classifier_tb;
	import bcc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [15:0]      s_tdata;   // [0] raw_pressed, [8:1] elapsed_ms, rest zero
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;   // [1:0] event_kind, rest zero
	int               mismatch_count;
	int               events_due;

	// pacing of both sides, in idle cycles per hundred
	int               send_idle_pct;
	int               recv_idle_pct;
	logic             hold_off_req;
	int               ticks_sent;

	// current timing registers, kept here only to scale the gestures
	int               deb_ms, lp_ms, gap_ms;
	int unsigned      dt_hi;

	button_click_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	button_click_classifier_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatch_count(mismatch_count),
		.events_due    (events_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block wedges or stops sending events.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Event sink. Hold m_tready low for one long stretch when asked, so the
	// output register fills and the block has to stall its tick input;
	// otherwise accept at the current random pace.
	initial begin
		int stall_left;
		bit stall_done;
		stall_left = 0;
		stall_done = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_off_req && !stall_done) begin
				stall_done = 1;
				stall_left = 80;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// Offer one tick and hold it until the transfer completes. Random idle
	// cycles go in front so that gaps land on every phase of the pipeline.
	task automatic send_tick(input logic raw, input logic [7:0] dt);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, dt, raw};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Keep the raw level for at least dur milliseconds of tick time.
	task automatic hold_for(input logic raw, input int dur);
		int unsigned acc;
		logic [7:0]  dt;
		acc = 0;
		do begin
			dt = 8'($urandom_range(dt_hi, 0));
			send_tick(raw, dt);
			acc += dt;
		end while (acc < dur);
	endtask

	// Contact bounce: up to three pairs of short flips ending on the target level.
	task automatic bounce(input logic level);
		repeat ($urandom_range(3, 0)) begin
			send_tick(~level, 8'($urandom_range(dt_hi / 4, 0)));
			send_tick(level, 8'($urandom_range(dt_hi / 4, 0)));
		end
	endtask

	// One press and release with random content; the durations straddle the
	// long-press and gap thresholds so every event kind turns up.
	task automatic random_gesture();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 45) begin
			bounce(1'b1);
			hold_for(1'b1, deb_ms + $urandom_range(lp_ms * 3 / 4, 0));
			bounce(1'b0);
			hold_for(1'b0, deb_ms + $urandom_range(gap_ms * 3 / 2, 0));
		end else if (pick < 70) begin
			bounce(1'b1);
			hold_for(1'b1, deb_ms + lp_ms + $urandom_range(lp_ms / 2, 0));
			bounce(1'b0);
			hold_for(1'b0, deb_ms + $urandom_range(gap_ms * 3 / 2, 0));
		end else if (pick < 85) begin
			// line noise: anything goes
			repeat ($urandom_range(6, 1))
				send_tick(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
		end else begin
			// quiet spell long enough to let a pending wait expire
			hold_for(1'b0, deb_ms + gap_ms + $urandom_range(gap_ms, 0));
		end
	endtask

	task automatic run_gestures(input int budget);
		int first;
		first = ticks_sent;
		while (ticks_sent - first < budget)
			random_gesture();
	endtask

	// Drop valid, let the last ticks reach the checker, then wait until no
	// event is still expected and wait once more after that, since a tick may
	// still be in flight without producing anything.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		repeat (4) @(posedge clk);
		while (events_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three timing registers one after another; idle only.
	task automatic apply_setting(input int d, input int l, input int g);
		int widest;
		cfg_we <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= CFG_W'(d);
		@(posedge clk);
		cfg_index <= REG_LONG_PRESS;
		cfg_wdata <= CFG_W'(l);
		@(posedge clk);
		cfg_index <= REG_GAP;
		cfg_wdata <= CFG_W'(g);
		@(posedge clk);
		cfg_we <= 1'b0;
		deb_ms = d;
		lp_ms = l;
		gap_ms = g;
		widest = (d > l) ? d : l;
		widest = (widest > g) ? widest : g;
		dt_hi = widest / 10;
		if (dt_hi < 3)
			dt_hi = 3;
		if (dt_hi > 255)
			dt_hi = 255;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		hold_off_req <= 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 61;
		ticks_sent = 0;
		deb_ms = int'(DEBOUNCE_RST);
		lp_ms = int'(LONG_PRESS_RST);
		gap_ms = int'(GAP_RST);
		dt_hi = 100;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks on the reset timing (20 / 1000 / 300).
		// First tick: stable level takes the raw level at once.
		send_tick(1'b1, 8'd0);
		// keep holding with the largest step until the long press fires
		repeat (4) send_tick(1'b1, 8'd255);
		// release after a long press: no click wait is armed
		send_tick(1'b0, 8'd0);
		send_tick(1'b0, 8'd255);
		// two quick clicks inside the gap give a double click
		send_tick(1'b1, 8'd10);
		send_tick(1'b1, 8'd10);
		send_tick(1'b1, 8'd10);
		send_tick(1'b0, 8'd5);
		send_tick(1'b0, 8'd30);
		send_tick(1'b1, 8'd5);
		send_tick(1'b1, 8'd25);
		send_tick(1'b0, 8'd3);
		send_tick(1'b0, 8'd25);
		// one click, then let the gap run out for a single click
		send_tick(1'b1, 8'd0);
		send_tick(1'b1, 8'd30);
		send_tick(1'b0, 8'd0);
		send_tick(1'b0, 8'd30);
		send_tick(1'b0, 8'd255);
		send_tick(1'b0, 8'd100);
		// bounce: raw flips restart debounce without touching the stable level
		send_tick(1'b1, 8'd1);
		send_tick(1'b0, 8'd1);
		send_tick(1'b1, 8'd1);
		send_tick(1'b0, 8'd1);
		run_gestures(200);
		wait_drained();

		// All timings zero: debounce never moves the stable level again.
		apply_setting(0, 0, 0);
		run_gestures(60);
		wait_drained();

		// Swap the idle pattern and go to long timings of 10000 ms.
		send_idle_pct = 61;
		recv_idle_pct = 16;
		apply_setting(10000, 10000, 10000);
		// hold long enough for the hold timer to saturate
		repeat (320) send_tick(1'b1, 8'd255);
		run_gestures(100);
		wait_drained();

		// Zero gap: a single click fires on the tick the wait is armed.
		apply_setting(5, 100, 0);
		run_gestures(200);
		wait_drained();

		// No idling from here on.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_setting($urandom_range(400, 0), $urandom_range(400, 0),
			$urandom_range(400, 0));
		run_gestures(200);
		wait_drained();

		// Zero long-press time: every debounced press reports at once. Stall
		// the sink for a long stretch while the ticks keep coming.
		apply_setting(1, 0, 0);
		hold_off_req <= 1'b1;
		repeat (25) begin
			send_tick(1'b1, 8'd1);
			send_tick(1'b1, 8'd1);
			send_tick(1'b0, 8'd1);
			send_tick(1'b0, 8'd1);
		end
		run_gestures(60);
		wait_drained();

		if (mismatch_count == 0 && events_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/bcc_pkg.sv
rtl/core/bcc_step.sv
rtl/core/button_click_classifier.sv
tb/button_click_classifier_checker.sv
tb/button_click_classifier_tb.sv
